### design/aglr_pkg.sv
// Shared types and constants for the anti-aliased glow line raster.
// No dependencies; imported by every design file.
package aglr_pkg;

  localparam int FbWidth  = 128;
  localparam int FbHeight = 64;
  localparam int XW = $clog2(FbWidth);
  localparam int YW = $clog2(FbHeight);
  localparam int AW = XW + YW;

  // Request codes.
  localparam logic [1:0] ReqLine  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  // Register indexes.
  localparam logic [1:0] CfgRed   = 2'd0;
  localparam logic [1:0] CfgGreen = 2'd1;
  localparam logic [1:0] CfgBlue  = 2'd2;

  localparam logic [7:0] EndCoverage = 8'd127;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_DIV, ST_COV, ST_PLOT, ST_RD,
    ST_MIX, ST_WB, ST_NEXT, ST_ACC, ST_RDWAIT, ST_OUT
  } state_e;

  // Which glow centre of a line is being plotted.
  typedef enum logic [1:0] {
    PH_END1, PH_END2, PH_LOW, PH_HIGH
  } phase_e;

endpackage

### design/aglr_blend.sv
// One channel blend: cur + trunc((col - cur) * a / 255), registered product.
// Depends on aglr_pkg.
module aglr_blend
  import aglr_pkg::*;
(
  input  logic       clk_i,
  input  logic [7:0] cur_i,
  input  logic [7:0] col_i,
  input  logic [7:0] alpha_i,
  output logic [7:0] new_o
);

  logic signed [17:0] prod_q;
  logic [17:0]        mag;
  logic [27:0]        recip;
  logic [9:0]         quo;
  logic [17:0]        rem;
  logic [8:0]         qfix;
  logic               neg_q;
  logic [7:0]         cur_q;

  // Stage one: signed product.
  always_ff @(posedge clk_i) begin
    prod_q <= (18'(signed'({1'b0, col_i})) - 18'(signed'({1'b0, cur_i})))
              * 18'(signed'({10'd0, alpha_i}));
    cur_q  <= cur_i;
    neg_q  <= col_i < cur_i;
  end

  // Stage two: divide magnitude by 255 via reciprocal plus one correction.
  always_comb begin
    mag   = neg_q ? 18'(-prod_q) : 18'(prod_q);
    recip = 28'(mag) * 28'd257;
    quo   = recip[25:16];
    rem   = mag - 18'(quo) * 18'd255;
    qfix  = (rem >= 18'd255) ? 9'(quo + 10'd1) : quo[8:0];
    new_o = neg_q ? 8'(cur_q - qfix[7:0]) : 8'(cur_q + qfix[7:0]);
  end

endmodule

### design/antialiased_glow_line_raster_core.sv
// Anti-aliased glow line rasterizer: top level with frame memory and sequencer.
// Depends on aglr_pkg and aglr_blend.
//
// Usage: a word on the input channel (valid/stall) is a line draw, a pixel
// write or a pixel read. Each word yields exactly one result word holding
// pixel_out and was_read. Line color comes from three 8-bit registers on
// the write port, which the user must keep to: it is to be written only while
// no word is in flight; the block itself does not enforce this. After reset
// the frame memory is cleared one pixel a cycle while in_stall_o is high.
// The block takes one word at a time. A write, an unused request or a
// zero-length line passes one state (ST_ACC or ST_SETUP) before its result
// in ST_OUT, a read passes ST_ACC and ST_RDWAIT; once the result is taken
// the next word is accepted in ST_IDLE. A line plots its two endpoints and
// two pixels per interior step. Each pixel is a glow of nine
// read-modify-write blends on the single frame memory: an on-screen blend
// passes ST_PLOT, ST_RD, ST_MIX, ST_WB and ST_NEXT, a skipped one only
// ST_PLOT and ST_NEXT. Each interior step adds the 8-step coverage divide
// and ST_COV.
// The result is held in an output register; while out_stall_i is high the
// block waits with the word in place and takes no new input.
module antialiased_glow_line_raster_core
  import aglr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  x_first_i,
  input  logic [5:0]  y_first_i,
  input  logic [6:0]  x_second_i,
  input  logic [5:0]  y_second_i,
  input  logic [23:0] pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] pixel_out_o,
  output logic        was_read_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  state_e state_q, state_d;

  // Frame memory. Blends run strictly one after another, so a write back
  // always lands before the next read is issued.
  logic [23:0]   mem [FbWidth*FbHeight];
  logic [23:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Color registers.
  logic [7:0] red_q, green_q, blue_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= 8'd215; green_q <= 8'd255; blue_q <= 8'd135;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRed:   red_q   <= cfg_data_i;
        CfgGreen: green_q <= cfg_data_i;
        CfgBlue:  blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item and line registers.
  logic [1:0]  req_q;
  logic [6:0]  xa_q, xb_q;
  logic [5:0]  ya_q, yb_q;
  logic [23:0] pix_q;
  logic        xmaj_q;
  logic [6:0]  ma1_q, ma2_q, mi1_q, mi2_q, i_q, m_q, r_q, dma_q;
  logic signed [7:0] dmi_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  nb_q, nb_d;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]  a_q, a_d;
  logic [23:0] out_pix_q, out_pix_d;
  logic        out_rd_q, out_rd_d;

  // Coverage divider: floor(255*r / dma), restoring, one quotient bit a cycle.
  logic [6:0]  dv_rem_q;
  logic [7:0]  dv_num_q, dv_quo_q;
  logic [2:0]  dv_cnt_q;
  logic [7:0]  c1_q, c2_q;

  // Line setup values, endpoints ordered along the major axis.
  logic signed [7:0] sdx, sdy, s_dmi;
  logic [6:0] adx, ady, s_dma, s_ma1, s_ma2, s_mi1, s_mi2;
  logic       xm;
  always_comb begin
    sdx = 8'(signed'({1'b0, xb_q})) - 8'(signed'({1'b0, xa_q}));
    sdy = 8'(signed'({2'b0, yb_q})) - 8'(signed'({2'b0, ya_q}));
    adx = sdx[7] ? 7'(-sdx) : sdx[6:0];
    ady = sdy[7] ? 7'(-sdy) : sdy[6:0];
    xm  = adx > ady;
    if (xm) begin
      s_dma = adx;
      if (xa_q > xb_q) begin
        s_ma1 = xb_q; s_ma2 = xa_q; s_mi1 = 7'(yb_q); s_mi2 = 7'(ya_q); s_dmi = -sdy;
      end else begin
        s_ma1 = xa_q; s_ma2 = xb_q; s_mi1 = 7'(ya_q); s_mi2 = 7'(yb_q); s_dmi = sdy;
      end
    end else begin
      s_dma = ady;
      if (ya_q > yb_q) begin
        s_ma1 = 7'(yb_q); s_ma2 = 7'(ya_q); s_mi1 = xb_q; s_mi2 = xa_q; s_dmi = -sdx;
      end else begin
        s_ma1 = 7'(ya_q); s_ma2 = 7'(yb_q); s_mi1 = xa_q; s_mi2 = xb_q; s_dmi = sdx;
      end
    end
  end

  // Next interior step: the remainder stays in [0, dma) and moves the minor
  // position by one when it wraps, since |dmi| never exceeds dma.
  logic signed [8:0] rsum, dma_s;
  logic [6:0]        r_nx, m_nx;
  logic [14:0]       dv_n;
  always_comb begin
    dma_s = signed'({2'b0, dma_q});
    rsum  = signed'({2'b0, r_q}) + 9'(dmi_q);
    if (rsum < 0) begin
      r_nx = 7'(rsum + dma_s);
      m_nx = m_q - 7'd1;
    end else if (rsum >= dma_s) begin
      r_nx = 7'(rsum - dma_s);
      m_nx = m_q + 7'd1;
    end else begin
      r_nx = rsum[6:0];
      m_nx = m_q;
    end
    dv_n = {r_nx, 8'd0} - 15'(r_nx);
  end

  // Divider step.
  logic [7:0] dv_trial;
  logic       dv_ge;
  always_comb begin
    dv_trial = {dv_rem_q, dv_num_q[7]};
    dv_ge    = dv_trial >= {1'b0, dma_q};
  end

  // Plot centre for the current phase, as (x, y), and the glow neighbor.
  logic signed [8:0] pmaj, pmin, cx, cy, nx, ny;
  logic signed [1:0] ox, oy;
  logic [7:0] cent_a, nb_a;
  always_comb begin
    unique case (phase_q)
      PH_END1: begin pmaj = 9'(ma1_q); pmin = 9'(mi1_q); cent_a = EndCoverage; end
      PH_END2: begin pmaj = 9'(ma2_q); pmin = 9'(mi2_q); cent_a = EndCoverage; end
      PH_LOW:  begin pmaj = 9'(i_q); pmin = 9'(m_q); cent_a = c1_q; end
      default: begin pmaj = 9'(i_q); pmin = 9'(m_q) + 9'sd1; cent_a = c2_q; end
    endcase
    cx = xmaj_q ? pmaj : pmin;
    cy = xmaj_q ? pmin : pmaj;
    unique case (nb_q)
      4'd0: begin ox = 2'sd0;  oy = 2'sd0;  end
      4'd1: begin ox = 2'sd1;  oy = 2'sd0;  end
      4'd2: begin ox = -2'sd1; oy = 2'sd0;  end
      4'd3: begin ox = 2'sd0;  oy = 2'sd1;  end
      4'd4: begin ox = 2'sd0;  oy = -2'sd1; end
      4'd5: begin ox = 2'sd1;  oy = 2'sd1;  end
      4'd6: begin ox = -2'sd1; oy = -2'sd1; end
      4'd7: begin ox = -2'sd1; oy = 2'sd1;  end
      default: begin ox = 2'sd1; oy = -2'sd1; end
    endcase
    nx = cx + 9'(ox);
    ny = cy + 9'(oy);
    nb_a = (nb_q == 4'd0) ? cent_a : (nb_q < 4'd5) ? {3'd0, cent_a[7:3]}
                                                  : {4'd0, cent_a[7:4]};
  end

  logic on_scr;
  assign on_scr = nx >= 0 && nx < 9'(FbWidth) && ny >= 0 && ny < 9'(FbHeight);

  // Blend units, one per channel.
  logic [7:0] nr, ng, nbl;
  aglr_blend u_r (.clk_i, .cur_i(rdata_q[23:16]), .col_i(red_q),   .alpha_i(a_q), .new_o(nr));
  aglr_blend u_g (.clk_i, .cur_i(rdata_q[15:8]),  .col_i(green_q), .alpha_i(a_q), .new_o(ng));
  aglr_blend u_b (.clk_i, .cur_i(rdata_q[7:0]),   .col_i(blue_q),  .alpha_i(a_q), .new_o(nbl));

  // Sequencer: next state and memory port control.
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    nb_d      = nb_q;
    addr_d    = addr_q;
    a_d       = a_q;
    out_pix_d = out_pix_q;
    out_rd_d  = out_rd_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = {nr, ng, nbl};
    raddr     = addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        if (clr_q == AW'(FbWidth*FbHeight-1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          out_pix_d = '0;
          out_rd_d  = 1'b0;
          state_d   = (req_type_i == ReqLine) ? ST_SETUP : ST_ACC;
        end
      end
      ST_SETUP: begin
        phase_d = PH_END1;
        nb_d    = '0;
        state_d = (sdx == 8'sd0 && sdy == 8'sd0) ? ST_OUT : ST_PLOT;
      end
      ST_PLOT: begin
        addr_d  = {ny[YW-1:0], nx[XW-1:0]};
        a_d     = nb_a;
        state_d = on_scr ? ST_RD : ST_NEXT;
      end
      // Read issued, then the product stage, then the write back.
      ST_RD:  state_d = ST_MIX;
      ST_MIX: state_d = ST_WB;
      ST_WB: begin
        we      = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (nb_q != 4'd8) begin
          nb_d    = nb_q + 4'd1;
          state_d = ST_PLOT;
        end else begin
          nb_d = '0;
          unique case (phase_q)
            PH_END1: begin phase_d = PH_END2; state_d = ST_PLOT; end
            PH_LOW:  begin phase_d = PH_HIGH; state_d = ST_PLOT; end
            default: state_d = (i_q + 7'd1 < ma2_q) ? ST_DIV : ST_OUT;
          endcase
        end
      end
      ST_DIV: begin
        if (dv_cnt_q == 3'd7) state_d = ST_COV;
      end
      ST_COV: begin
        phase_d = PH_LOW;
        nb_d    = '0;
        state_d = ST_PLOT;
      end
      ST_ACC: begin
        raddr = {ya_q, xa_q};
        if (req_q == ReqWrite) begin
          we    = 1'b1;
          waddr = {ya_q, xa_q};
          wdata = pix_q;
        end
        out_rd_d = (req_q == ReqRead);
        state_d  = (req_q == ReqRead) ? ST_RDWAIT : ST_OUT;
      end
      ST_RDWAIT: begin
        out_pix_d = rdata_q;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Registers of the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; phase_q <= PH_END1; nb_q <= '0;
      out_rd_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; nb_q <= nb_d; out_rd_q <= out_rd_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d; a_q <= a_d; out_pix_q <= out_pix_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= req_type_i; xa_q <= x_first_i; ya_q <= y_first_i;
      xb_q <= x_second_i; yb_q <= y_second_i; pix_q <= pixel_in_i;
    end
    if (state_q == ST_SETUP) begin
      xmaj_q <= xm;
      ma1_q <= s_ma1; ma2_q <= s_ma2; mi1_q <= s_mi1; mi2_q <= s_mi2;
      dmi_q <= s_dmi; dma_q <= s_dma;
      i_q <= s_ma1; m_q <= s_mi1; r_q <= '0;
    end
    // Advance to the next interior step and load the coverage divide.
    if (state_q == ST_NEXT && state_d == ST_DIV) begin
      i_q <= i_q + 7'd1; m_q <= m_nx; r_q <= r_nx;
      dv_rem_q <= dv_n[14:8]; dv_num_q <= dv_n[7:0];
      dv_quo_q <= '0; dv_cnt_q <= '0;
    end
    if (state_q == ST_DIV) begin
      dv_rem_q <= dv_ge ? 7'(dv_trial - {1'b0, dma_q}) : dv_trial[6:0];
      dv_num_q <= {dv_num_q[6:0], 1'b0};
      dv_quo_q <= {dv_quo_q[6:0], dv_ge};
      dv_cnt_q <= dv_cnt_q + 3'd1;
    end
    // The low pixel gets 255 minus the ceiling of the high pixel's share.
    if (state_q == ST_COV) begin
      c2_q <= dv_quo_q;
      c1_q <= 8'd255 - dv_quo_q - {7'd0, dv_rem_q != 7'd0};
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign pixel_out_o = out_pix_q;
  assign was_read_o  = out_rd_q;

endmodule

### design/aglr_checker.sv
// Port-level checker for the raster core, bound to the top level.
// Depends on aglr_pkg.
module aglr_checker
  import aglr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] pixel_out_o,
  input logic        was_read_o
);

  // A result word is never shown while the input side is open.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("result while accepting");

  // Non-read results carry zero pixel data.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_read_o |-> pixel_out_o == 24'd0) else $error("stray pixel data");

  // A stalled result stays.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("result dropped");

  // An accepted word is followed by a busy input side.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("no busy after accept");

endmodule

bind antialiased_glow_line_raster_core aglr_checker u_chk (.*);
